// ----- design/plsa_pkg.sv -----
package plsa_pkg;

  localparam int NumSources = 3;
  localparam int SrcW       = (NumSources > 1) ? $clog2(NumSources) : 1;

  localparam int TypeW    = 2;
  localparam int ColorW   = 32;
  localparam int FlashW   = 2;
  localparam int TimeW    = 32;
  localparam int BmodeW   = 2;
  localparam int LevelW   = 16;
  localparam int InDataW  = 104;
  localparam int OutDataW = 24;
  localparam int OutPayW  = 19;

  localparam logic [FlashW-1:0] FlashTimed = 2'd1;
  localparam logic [FlashW-1:0] FlashHw    = 2'd2;

  localparam logic [LevelW-1:0] MaxBrightReset = 16'd255;
  localparam logic [24:0]       Recip254       = 25'd16909320;
  localparam logic [7:0]        Div254         = 8'd254;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [FlashW-1:0] flash;
    logic [TimeW-1:0]  on_time;
    logic [TimeW-1:0]  off_time;
    logic [BmodeW-1:0] bmode;
  } rec_t;

  typedef rec_t cache_t [NumSources];

  typedef struct packed {
    logic [LevelW-1:0] led_level;
    logic              breath_on;
    logic              driven;
    logic              status;
  } result_t;

  typedef enum logic [3:0] {
    StIdle,
    StWrite,
    StCmp,
    StMula,
    StDiv,
    StLum,
    StProd,
    StRecip,
    StCorr,
    StDone
  } state_e;

  typedef struct packed {
    logic load_req;
    logic cache_we;
    logic compare;
    logic mula;
    logic div;
    logic lum;
    logic prod;
    logic recip;
    logic corr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic unsup;
    logic out_busy;
  } sts_t;

  function automatic rec_t pick_winner(input cache_t c);
    rec_t w;
    logic found;
    w     = c[NumSources-1];
    found = 1'b0;
    for (int i = 0; i < NumSources; i++) begin
      if (!found && (c[i].color[23:0] != 24'd0)) begin
        w     = c[i];
        found = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ----- design/plsa_ctrl.sv -----
module plsa_ctrl import plsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        state_d = sts_i.unsup ? StDone : StCmp;
      end
      StCmp:   state_d = StMula;
      StMula:  state_d = StDiv;
      StDiv:   state_d = StLum;
      StLum:   state_d = StProd;
      StProd:  state_d = StRecip;
      StRecip: state_d = StCorr;
      StCorr:  state_d = StDone;
      StDone: begin
        if (!sts_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      StWrite: cmd_o.cache_we = !sts_i.unsup;
      StCmp:   cmd_o.compare  = 1'b1;
      StMula:  cmd_o.mula     = 1'b1;
      StDiv:   cmd_o.div      = 1'b1;
      StLum:   cmd_o.lum      = 1'b1;
      StProd:  cmd_o.prod     = 1'b1;
      StRecip: cmd_o.recip    = 1'b1;
      StCorr:  cmd_o.corr     = 1'b1;
      StDone:  cmd_o.load_out = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- design/plsa_dp.sv -----
module plsa_dp import plsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [TypeW-1:0]    in_type_i,
  input  logic                cfg_valid_i,
  input  logic [LevelW-1:0]   cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic [LevelW-1:0] max_q;
  logic [TypeW-1:0]  type_q;
  rec_t              req_q;
  cache_t            cache_q;
  rec_t              before_q;
  logic              changed_q;
  logic [ColorW-1:0] win_color_q;
  logic [FlashW-1:0] win_flash_q;
  logic [15:0]       pr_q, pg_q, pb_q;
  logic [7:0]        qr_q, qg_q, qb_q;
  logic [7:0]        lum_q;
  logic [23:0]       prod_q;
  logic [LevelW-1:0] qe_q;
  logic [LevelW-1:0] level_q;
  logic              out_valid_q;
  result_t           out_q;

  logic              unsup;
  logic [SrcW-1:0]   idx;
  rec_t              winner;
  logic [LevelW-1:0] mx;
  logic [LevelW-1:0] mx_m1;
  logic [7:0]        lum_m1;
  logic [15:0]       lum_sum;
  logic [48:0]       recip_p;
  logic [23:0]       qe_mul;
  logic [23:0]       rem;
  logic              bump;
  logic              drv;
  logic              lit;
  logic              brth;
  result_t           res;

  assign unsup   = int'(type_q) >= NumSources;
  assign idx     = SrcW'(type_q);
  assign winner  = pick_winner(cache_q);
  assign mx      = (max_q == '0) ? LevelW'(1) : max_q;
  assign mx_m1   = mx - LevelW'(1);
  assign lum_m1  = lum_q - 8'd1;
  assign lum_sum = 16'd77 * 16'(qr_q) + 16'd150 * 16'(qg_q) + 16'd29 * 16'(qb_q);
  assign recip_p = 49'(prod_q) * 49'(Recip254);
  assign qe_mul  = 24'(qe_q) * 24'(Div254);
  assign rem     = prod_q - qe_mul;
  assign bump    = rem >= 24'(Div254);

  assign drv  = !unsup && changed_q;
  assign lit  = drv && (lum_q != 8'd0);
  assign brth = lit && ((win_flash_q == FlashTimed) || (win_flash_q == FlashHw));

  always_comb begin
    res.status    = unsup;
    res.driven    = drv;
    res.breath_on = brth;
    res.led_level = (lit && !brth) ? level_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxBrightReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSources; i++) begin
        cache_q[i] <= '0;
      end
    end else if (cmd_i.cache_we) begin
      cache_q[idx] <= req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      type_q         <= in_type_i;
      req_q.color    <= in_data_i[31:0];
      req_q.flash    <= in_data_i[33:32];
      req_q.on_time  <= in_data_i[65:34];
      req_q.off_time <= in_data_i[97:66];
      req_q.bmode    <= in_data_i[99:98];
    end
    if (cmd_i.cache_we) begin
      before_q <= winner;
    end
    if (cmd_i.compare) begin
      changed_q   <= winner != before_q;
      win_color_q <= winner.color;
      win_flash_q <= winner.flash;
    end
    if (cmd_i.mula) begin
      pr_q <= 16'(win_color_q[23:16]) * 16'(win_color_q[31:24]);
      pg_q <= 16'(win_color_q[15:8]) * 16'(win_color_q[31:24]);
      pb_q <= 16'(win_color_q[7:0]) * 16'(win_color_q[31:24]);
    end
    if (cmd_i.div) begin
      qr_q <= div255(pr_q);
      qg_q <= div255(pg_q);
      qb_q <= div255(pb_q);
    end
    if (cmd_i.lum) begin
      lum_q <= lum_sum[15:8];
    end
    if (cmd_i.prod) begin
      prod_q <= 24'(lum_m1) * 24'(mx_m1);
    end
    if (cmd_i.recip) begin
      qe_q <= recip_p[47:32];
    end
    if (cmd_i.corr) begin
      level_q <= qe_q + LevelW'(bump) + LevelW'(1);
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.unsup    = unsup;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = {(OutDataW - OutPayW)'(0), out_q};

`ifndef SYNTHESIS
  a_no_write_unsup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cache_we |-> !unsup)
    else $error("cache written for unsupported type");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while pending");

  a_level_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.corr && (lum_q != 8'd0)) |=> level_q != '0)
    else $error("rescaled level is zero");

  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.status && out_q.driven))
    else $error("unsupported type reported as driven");

  a_breath_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.breath_on && (out_q.led_level != '0)))
    else $error("breathing with steady level");
`endif

endmodule

// ----- design/priority_led_state_arbiter.sv -----
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid / tready       tuser: light_type; tdata: argb_color,
//                                            flash_mode, flash_on_ms, flash_off_ms,
//                                            bright_mode
// m_axis    out        tvalid / tready       tdata: status, driven, breath_on, led_level
// cfg       in         valid / ready         data: peak LED level
//
// A request is taken only in the idle step; a supported one then runs the fixed
// step sequence of the controller, while an unsupported type goes from write to done.
// The result register lets a new request start while a result is pending; the
// controller holds in its final step only if the previous result is still there.
// Reset clears the three cached source states and sets the peak level to 255.
module priority_led_state_arbiter import plsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] argb_color, [33:32] flash_mode, [65:34] flash_on_ms,
  // [97:66] flash_off_ms, [99:98] bright_mode, [103:100] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] light_type
  input  logic [TypeW-1:0]    s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] status, [1] driven, [2] breath_on, [18:3] led_level, [23:19] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LevelW-1:0]   cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  plsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_type_i   (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
